>>> hw/rtl/bfd_pkg.sv
// Shared constants for the box-from-face-and-depth pipeline.
`timescale 1ns / 1ps
package bfd_pkg;
    // Configuration register indexes.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    // Weight selector codes; the unused code falls back to depth.
    localparam logic [1:0] MODE_DEPTH = 2'd0;
    localparam logic [1:0] MODE_REAL  = 2'd1;
    localparam logic [1:0] MODE_IMAG  = 2'd2;

    localparam int CORNERS = 8;
    localparam logic [2:0] LAST_CORNER = 3'd7;

    // Normalized cross product magnitudes, their sum of squares and its root.
    localparam int MAG_W  = 31;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    localparam int NORM_LAT = 8;
endpackage

>>> hw/rtl/bfd_delay.sv
// Enable-gated shift line that keeps side data aligned with the pipeline.
`timescale 1ns / 1ps
module bfd_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] line_reg [D];

    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= din;
            for (int i = 1; i < D; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[D-1];
endmodule

>>> hw/rtl/bfd_norm.sv
// Cross product, magnitude, common normalizing shift and sum of squares.
`timescale 1ns / 1ps
module bfd_norm (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [31:0]        a_in [3],
    input  logic signed [31:0]        b_in [3],
    output logic [bfd_pkg::MAG_W-1:0] m_out [3],
    output logic [2:0]                neg_out,
    output logic                      nz_out,
    output logic [bfd_pkg::SUM_W-1:0] sum_out
);
    import bfd_pkg::*;

    logic signed [63:0] prod_reg [6];
    logic signed [64:0] c_reg [3];
    logic [63:0]        mag_reg [3];
    logic [63:0]        mag2_reg [3];
    logic [63:0]        mag3_reg [3];
    logic [2:0]         neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [3:0]         any_reg;
    logic [3:0]         cpos_reg [4];
    logic [5:0]         pos_reg;
    logic               nz3_reg, nz4_reg, nz5_reg, nz6_reg;
    logic [MAG_W-1:0]   m4_reg [3];
    logic [MAG_W-1:0]   m5_reg [3];
    logic [MAG_W-1:0]   m6_reg [3];
    logic [2*MAG_W-1:0] sq_reg [3];
    logic [SUM_W-1:0]   sum_reg;

    logic [63:0] or_w;
    logic [3:0]  any_w;
    logic [3:0]  cpos_w [4];

    // Per 16-bit chunk: does it hold a one, and where is its highest one.
    always_comb begin
        or_w = mag_reg[0] | mag_reg[1] | mag_reg[2];
        for (int c = 0; c < 4; c++) begin
            any_w[c]  = |or_w[16*c +: 16];
            cpos_w[c] = '0;
            for (int b = 0; b < 16; b++) begin
                if (or_w[16*c + b]) begin
                    cpos_w[c] = 4'(b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= a_in[1] * b_in[2];
            prod_reg[1] <= a_in[2] * b_in[1];
            prod_reg[2] <= a_in[2] * b_in[0];
            prod_reg[3] <= a_in[0] * b_in[2];
            prod_reg[4] <= a_in[0] * b_in[1];
            prod_reg[5] <= a_in[1] * b_in[0];

            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= 65'(prod_reg[2*i]) - 65'(prod_reg[2*i+1]);
            end

            for (int i = 0; i < 3; i++) begin
                neg1_reg[i] <= c_reg[i][64];
                mag_reg[i]  <= c_reg[i][64] ? 64'(-c_reg[i]) : 64'(c_reg[i]);
            end

            mag2_reg <= mag_reg;
            neg2_reg <= neg1_reg;
            any_reg  <= any_w;
            cpos_reg <= cpos_w;

            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            nz3_reg  <= ~|any_reg;
            if (any_reg[3]) begin
                pos_reg <= {2'd3, cpos_reg[3]};
            end else if (any_reg[2]) begin
                pos_reg <= {2'd2, cpos_reg[2]};
            end else if (any_reg[1]) begin
                pos_reg <= {2'd1, cpos_reg[1]};
            end else begin
                pos_reg <= {2'd0, cpos_reg[0]};
            end

            // Bring the largest magnitude into [2^30, 2^31).
            for (int i = 0; i < 3; i++) begin
                if (pos_reg >= 6'(MAG_W - 1)) begin
                    m4_reg[i] <= MAG_W'(mag3_reg[i] >> (pos_reg - 6'(MAG_W - 1)));
                end else begin
                    m4_reg[i] <= MAG_W'(mag3_reg[i] << (6'(MAG_W - 1) - pos_reg));
                end
            end
            neg4_reg <= neg3_reg;
            nz4_reg  <= nz3_reg;

            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= m4_reg[i] * m4_reg[i];
            end
            m5_reg   <= m4_reg;
            neg5_reg <= neg4_reg;
            nz5_reg  <= nz4_reg;

            sum_reg  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            m6_reg   <= m5_reg;
            neg6_reg <= neg5_reg;
            nz6_reg  <= nz5_reg;
        end
    end

    assign m_out   = m6_reg;
    assign neg_out = neg6_reg;
    assign nz_out  = nz6_reg;
    assign sum_out = sum_reg;
endmodule

>>> hw/rtl/bfd_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module bfd_isqrt (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [bfd_pkg::SUM_W-1:0]  x_in,
    output logic [bfd_pkg::ROOT_W-1:0] root
);
    import bfd_pkg::*;

    logic [SUM_W-1:0] x_reg [ROOT_W];
    logic [SUM_W-1:0] r_reg [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2*j);
        logic [SUM_W-1:0] xi;
        logic [SUM_W-1:0] ri;
        logic [SUM_W-1:0] trial;

        if (j == 0) begin : g_first
            assign xi = x_in;
            assign ri = '0;
        end else begin : g_next
            assign xi = x_reg[j-1];
            assign ri = r_reg[j-1];
        end

        assign trial = ri + BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (xi >= trial) begin
                    x_reg[j] <= xi - trial;
                    r_reg[j] <= (ri >> 1) + BIT;
                end else begin
                    x_reg[j] <= xi;
                    r_reg[j] <= ri >> 1;
                end
            end
        end
    end

    assign root = ROOT_W'(r_reg[ROOT_W-1]);
endmodule

>>> hw/rtl/bfd_div.sv
// Pipelined restoring divider for one normal component, rounded to nearest.
`timescale 1ns / 1ps
module bfd_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [bfd_pkg::MAG_W-1:0]  m_in,
    input  logic [bfd_pkg::ROOT_W-1:0] len_in,
    output logic [FRAC_BITS+1:0]       q_out
);
    import bfd_pkg::*;

    localparam int QB = FRAC_BITS + 2;
    localparam int RW = FRAC_BITS + 34;

    logic [RW-1:0]     rem_reg [QB+1];
    logic [ROOT_W-1:0] den_reg [QB+1];
    logic [QB-1:0]     q_reg   [QB+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= RW'({m_in, {FRAC_BITS{1'b0}}}) + RW'(len_in >> 1);
            den_reg[0] <= len_in;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        localparam int SH = QB - k;
        logic [RW-1:0] trial;

        assign trial = RW'(den_reg[k-1]) << SH;

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k] <= den_reg[k-1];
                if (rem_reg[k-1] >= trial) begin
                    rem_reg[k] <= rem_reg[k-1] - trial;
                    q_reg[k]   <= q_reg[k-1] | (QB'(1) << SH);
                end else begin
                    rem_reg[k] <= rem_reg[k-1];
                    q_reg[k]   <= q_reg[k-1];
                end
            end
        end
    end

    assign q_out = q_reg[QB];
endmodule

>>> hw/rtl/box_from_face_and_depth.sv
// The corner output register hands out one corner word per cycle while m_tready is high,
// eight words per input word, so it is the limiting stage; it takes a new input word
// only once it is idle or is handing out the last corner of the item it holds.
// The front end is a fully pipelined datapath that stalls as a whole while an item
// waits at its tail and the corner register still holds undelivered words.
// Reset clears all valid bits and the output state and sets the mode to depth and
// the height ratio to 1.0.
`timescale 1ns / 1ps
module box_from_face_and_depth #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [bfd_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [30:0]                       cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // base_x, base_y, base_z, edge_a_x/y/z, edge_b_x/y/z, depth, weight_real,
    // weight_imag; 32 bits each from the lowest bit up.
    input  logic [383:0]                      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // corner_x, corner_y, corner_z, value_x, value_y, value_z; 32 bits each.
    output logic [191:0]                      m_tdata,
    // corner_number[2:0], depth_zero, weight_zero, normal_zero, two zero bits.
    output logic [7:0]                        m_tuser,
    output logic                              m_tlast
);
    import bfd_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int QB    = F + 2;
    localparam int NW    = F + 3;
    localparam int PW    = F + 35;
    localparam int RMW   = 36;
    localparam int PLW   = 47;
    localparam int PHW   = 52;
    localparam int HPW   = 68;
    localparam int HMW   = HPW - F;
    localparam int HW    = HMW + 1;
    localparam int QW    = HW + 1;
    localparam int CW    = QW + 2;
    localparam int VL    = F + 56;
    localparam int D_DW  = F + 43;
    localparam int D_P   = F + 51;
    localparam int D_AB  = F + 52;
    localparam int D_FL  = F + 43;
    localparam int D_NEG = F + 35;

    localparam logic [PW-1:0]  D_HALF = PW'(1) << (F - 1);
    localparam logic [HPW-1:0] H_HALF = HPW'(1) << (F - 1);
    localparam logic signed [CW-1:0]  C_MAX = CW'(32'sh7fffffff);
    localparam logic signed [CW-1:0]  C_MIN = CW'(signed'(32'h80000000));
    localparam logic signed [RMW-1:0] V_MAX = RMW'(32'sh7fffffff);
    localparam logic signed [RMW-1:0] V_MIN = RMW'(signed'(32'h80000000));

    function automatic logic [31:0] sat_c(input logic signed [CW-1:0] x);
        logic [31:0] r;
        if (x > C_MAX) r = 32'h7fffffff;
        else if (x < C_MIN) r = 32'h80000000;
        else r = x[31:0];
        return r;
    endfunction

    function automatic logic [31:0] sat_v(input logic signed [RMW-1:0] x);
        logic [31:0] r;
        if (x > V_MAX) r = 32'h7fffffff;
        else if (x < V_MIN) r = 32'h80000000;
        else r = x[31:0];
        return r;
    endfunction

    // Configuration.
    logic [1:0]  mode_reg;
    logic [30:0] hr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_DEPTH;
            hr_reg   <= 31'(1) << F;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_MODE:   mode_reg <= cfg_wdata[1:0];
                REG_HEIGHT: hr_reg   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Pipeline control.
    logic          en;
    logic          load;
    logic          tail_valid;
    logic [VL-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[VL-2:0], s_tvalid};
        end
    end

    assign tail_valid = vld_reg[VL-1];
    assign s_tready   = en;

    // Input stage.
    logic signed [31:0] in_p_reg [3];
    logic signed [31:0] in_a_reg [3];
    logic signed [31:0] in_b_reg [3];
    logic signed [31:0] in_dep_reg;
    logic signed [31:0] in_w_reg;
    logic               in_dz_reg;
    logic               in_wz_reg;
    logic signed [31:0] w_sel;

    always_comb begin
        case (mode_reg)
            MODE_REAL: w_sel = s_tdata[32*10 +: 32];
            MODE_IMAG: w_sel = s_tdata[32*11 +: 32];
            default:   w_sel = s_tdata[32*9 +: 32];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                in_p_reg[i] <= s_tdata[32*i +: 32];
                in_a_reg[i] <= s_tdata[32*(3+i) +: 32];
                in_b_reg[i] <= s_tdata[32*(6+i) +: 32];
            end
            in_dep_reg <= s_tdata[32*9 +: 32];
            in_w_reg   <= w_sel;
            in_dz_reg  <= (s_tdata[32*9 +: 32] == 32'd0);
            in_wz_reg  <= (w_sel == 32'sd0);
        end
    end

    // Unit normal.
    logic [MAG_W-1:0]  nm_m [3];
    logic [2:0]        nm_neg;
    logic              nm_nz;
    logic [SUM_W-1:0]  nm_sum;
    logic [ROOT_W-1:0] len_w;
    logic [3*MAG_W-1:0] m_dly;
    logic [MAG_W-1:0]  m_al [3];
    logic [QB-1:0]     q_w [3];

    bfd_norm u_norm (
        .aclk    (aclk),
        .en      (en),
        .a_in    (in_a_reg),
        .b_in    (in_b_reg),
        .m_out   (nm_m),
        .neg_out (nm_neg),
        .nz_out  (nm_nz),
        .sum_out (nm_sum)
    );

    bfd_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .x_in (nm_sum),
        .root (len_w)
    );

    bfd_delay #(.W(3*MAG_W), .D(ROOT_W)) u_dly_m (
        .aclk (aclk),
        .en   (en),
        .din  ({nm_m[2], nm_m[1], nm_m[0]}),
        .dout (m_dly)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        assign m_al[i] = m_dly[MAG_W*i +: MAG_W];
        bfd_div #(.FRAC_BITS(F)) u_div (
            .aclk   (aclk),
            .en     (en),
            .m_in   (m_al[i]),
            .len_in (len_w),
            .q_out  (q_w[i])
        );
    end

    // Side data kept in step with the datapath.
    logic [3:0]   nz_neg_d;
    logic [1:0]   dzwz_d;
    logic [63:0]  depw_d;
    logic [95:0]  p_d;
    logic [191:0] ab_d;

    bfd_delay #(.W(4), .D(D_NEG)) u_dly_neg (
        .aclk (aclk), .en (en), .din ({nm_nz, nm_neg}), .dout (nz_neg_d)
    );
    bfd_delay #(.W(2), .D(D_FL)) u_dly_fl (
        .aclk (aclk), .en (en), .din ({in_wz_reg, in_dz_reg}), .dout (dzwz_d)
    );
    bfd_delay #(.W(64), .D(D_DW)) u_dly_dw (
        .aclk (aclk), .en (en), .din ({in_w_reg, in_dep_reg}), .dout (depw_d)
    );
    bfd_delay #(.W(96), .D(D_P)) u_dly_p (
        .aclk (aclk), .en (en),
        .din  ({in_p_reg[2], in_p_reg[1], in_p_reg[0]}),
        .dout (p_d)
    );
    bfd_delay #(.W(192), .D(D_AB)) u_dly_ab (
        .aclk (aclk), .en (en),
        .din  ({in_b_reg[2], in_b_reg[1], in_b_reg[0],
                in_a_reg[2], in_a_reg[1], in_a_reg[0]}),
        .dout (ab_d)
    );

    // Scaling, height and corner stages.
    logic signed [NW-1:0]  n_reg [3];
    logic signed [PW-1:0]  dprod_reg [3];
    logic signed [PW-1:0]  vprod_reg [3];
    logic [RMW-1:0]        dmag_reg [3];
    logic [RMW-1:0]        vmag_reg [3];
    logic [2:0]            dneg_reg, vneg_reg;
    logic signed [RMW-1:0] d_reg [3];
    logic signed [RMW-1:0] v_reg [3];
    logic [PLW-1:0]        pl_reg [3];
    logic signed [PHW-1:0] ph_reg [3];
    logic [95:0]           v5_reg;
    logic signed [HPW-1:0] hp_reg [3];
    logic [HMW-1:0]        hmag_reg [3];
    logic [2:0]            hneg7_reg, hneg8_reg;
    logic signed [HW-1:0]  h8_reg [3];
    logic [HMW-1:0]        half_reg [3];
    logic signed [QW-1:0]  q9_reg [3];
    logic signed [HW-1:0]  h9_reg [3];
    logic signed [CW-1:0]  q10_reg [3];
    logic signed [CW-1:0]  qa_reg [3];
    logic signed [CW-1:0]  qb_reg [3];
    logic signed [CW-1:0]  bh_reg [3];
    logic signed [CW-1:0]  b10_reg [3];
    logic signed [CW-1:0]  h10_reg [3];
    logic signed [CW-1:0]  cor_reg [CORNERS][3];
    logic [31:0]           csat_reg [CORNERS][3];
    logic [2:0]            fl_reg [12];
    logic signed [31:0]    dep1_reg, w1_reg;
    logic [95:0]           v12_w;

    logic [PW-1:0]  dabs_w [3];
    logic [PW-1:0]  vabs_w [3];
    logic [HPW-1:0] habs_w [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dabs_w[i] = dprod_reg[i][PW-1] ? PW'(-dprod_reg[i]) : PW'(dprod_reg[i]);
            vabs_w[i] = vprod_reg[i][PW-1] ? PW'(-vprod_reg[i]) : PW'(vprod_reg[i]);
            habs_w[i] = hp_reg[i][HPW-1] ? HPW'(-hp_reg[i]) : HPW'(hp_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Sign the quotients; parallel edges give a zero normal.
            for (int i = 0; i < 3; i++) begin
                if (nz_neg_d[3]) begin
                    n_reg[i] <= '0;
                end else if (nz_neg_d[i]) begin
                    n_reg[i] <= -$signed(NW'(q_w[i]));
                end else begin
                    n_reg[i] <= $signed(NW'(q_w[i]));
                end
            end
            dep1_reg  <= depw_d[31:0];
            w1_reg    <= depw_d[63:32];
            fl_reg[0] <= {nz_neg_d[3], dzwz_d[1], dzwz_d[0]};
            for (int s = 1; s < 12; s++) begin
                fl_reg[s] <= fl_reg[s-1];
            end

            for (int i = 0; i < 3; i++) begin
                dprod_reg[i] <= PW'(n_reg[i]) * PW'(dep1_reg);
                vprod_reg[i] <= PW'(n_reg[i]) * PW'(w1_reg);
            end

            for (int i = 0; i < 3; i++) begin
                dmag_reg[i] <= RMW'((dabs_w[i] + D_HALF) >> F);
                vmag_reg[i] <= RMW'((vabs_w[i] + D_HALF) >> F);
                dneg_reg[i] <= dprod_reg[i][PW-1];
                vneg_reg[i] <= vprod_reg[i][PW-1];
            end

            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= dneg_reg[i] ? -$signed(dmag_reg[i]) : $signed(dmag_reg[i]);
                v_reg[i] <= vneg_reg[i] ? -$signed(vmag_reg[i]) : $signed(vmag_reg[i]);
            end

            // Height product in two partial products, summed in the next stage.
            for (int i = 0; i < 3; i++) begin
                pl_reg[i] <= d_reg[i][15:0] * hr_reg;
                ph_reg[i] <= $signed(d_reg[i][RMW-1:16]) * $signed({1'b0, hr_reg});
            end
            v5_reg <= {sat_v(v_reg[2]), sat_v(v_reg[1]), sat_v(v_reg[0])};

            for (int i = 0; i < 3; i++) begin
                hp_reg[i] <= (HPW'(ph_reg[i]) <<< 16) + $signed({21'd0, pl_reg[i]});
            end

            for (int i = 0; i < 3; i++) begin
                hmag_reg[i]  <= HMW'((habs_w[i] + H_HALF) >> F);
                hneg7_reg[i] <= hp_reg[i][HPW-1];
            end

            for (int i = 0; i < 3; i++) begin
                h8_reg[i]   <= hneg7_reg[i] ? -$signed({1'b0, hmag_reg[i]})
                                            : $signed({1'b0, hmag_reg[i]});
                half_reg[i] <= HMW'(({1'b0, hmag_reg[i]} + (HMW+1)'(1)) >> 1);
                hneg8_reg[i] <= hneg7_reg[i];
            end

            // The base point moves back by half the height.
            for (int i = 0; i < 3; i++) begin
                if (hneg8_reg[i]) begin
                    q9_reg[i] <= QW'($signed(p_d[32*i +: 32]))
                                 + $signed(QW'({1'b0, half_reg[i]}));
                end else begin
                    q9_reg[i] <= QW'($signed(p_d[32*i +: 32]))
                                 - $signed(QW'({1'b0, half_reg[i]}));
                end
                h9_reg[i] <= h8_reg[i];
            end

            for (int i = 0; i < 3; i++) begin
                q10_reg[i] <= CW'(q9_reg[i]);
                qa_reg[i]  <= CW'(q9_reg[i]) + CW'($signed(ab_d[32*i +: 32]));
                qb_reg[i]  <= CW'(q9_reg[i]) + CW'($signed(ab_d[32*(3+i) +: 32]));
                bh_reg[i]  <= CW'($signed(ab_d[32*(3+i) +: 32])) + CW'(h9_reg[i]);
                b10_reg[i] <= CW'($signed(ab_d[32*(3+i) +: 32]));
                h10_reg[i] <= CW'(h9_reg[i]);
            end

            for (int i = 0; i < 3; i++) begin
                cor_reg[0][i] <= q10_reg[i];
                cor_reg[1][i] <= qa_reg[i];
                cor_reg[2][i] <= qb_reg[i];
                cor_reg[3][i] <= qa_reg[i] + b10_reg[i];
                cor_reg[4][i] <= q10_reg[i] + h10_reg[i];
                cor_reg[5][i] <= qa_reg[i] + h10_reg[i];
                cor_reg[6][i] <= qb_reg[i] + h10_reg[i];
                cor_reg[7][i] <= qa_reg[i] + bh_reg[i];
            end

            for (int k = 0; k < CORNERS; k++) begin
                for (int i = 0; i < 3; i++) begin
                    csat_reg[k][i] <= sat_c(cor_reg[k][i]);
                end
            end
        end
    end

    bfd_delay #(.W(96), .D(7)) u_dly_v (
        .aclk (aclk), .en (en), .din (v5_reg), .dout (v12_w)
    );

    // Corner output register: holds one item and hands out its eight words.
    logic        busy_reg, busy_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] hold_c_reg [CORNERS][3];
    logic [95:0] hold_v_reg;
    logic [2:0]  hold_fl_reg;

    assign load = tail_valid && (!busy_reg || (m_tready && cnt_reg == LAST_CORNER));
    assign en   = !tail_valid || load;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg && m_tready) begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == LAST_CORNER) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hold_c_reg  <= csat_reg;
            hold_v_reg  <= v12_w;
            hold_fl_reg <= fl_reg[11];
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {hold_v_reg, hold_c_reg[cnt_reg][2], hold_c_reg[cnt_reg][1],
                       hold_c_reg[cnt_reg][0]};
    assign m_tuser  = {2'b00, hold_fl_reg, cnt_reg};
    assign m_tlast  = (cnt_reg == LAST_CORNER);

`ifndef SYNTHESIS
    a_cnt_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 3'd0) |-> busy_reg)
        else $error("corner counter runs without a held item");

    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (busy_reg && cnt_reg == 3'd0))
        else $error("loaded item does not start at the first corner");

    a_hold_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !m_tready) |=> $stable(cnt_reg))
        else $error("corner counter moved while the output stalled");

    a_tail_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_valid && !en) |=> tail_valid)
        else $error("pipeline tail lost an item during a stall");
`endif
endmodule

>>> test/box_from_face_and_depth_test.sv
// Self-checking testbench for the box-from-face-and-depth corner generator.
`timescale 1ns / 1ps
module box_from_face_and_depth_test;
    import bfd_pkg::*;

    localparam int FRAC = 16;
    localparam int DRAIN_CYCLES = FRAC + 57 + 16;

    typedef struct {
        logic [191:0] corner_data;
        logic [7:0]   flags;
        logic         last;
    } corner_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wen = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = REG_MODE;
    logic [30:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [383:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic [7:0]   m_tuser;
    logic         m_tlast;

    logic [383:0] pending_faces[$];
    corner_word_t expected_corners[$];
    logic [1:0]   mode_copy = MODE_DEPTH;
    logic [30:0]  ratio_copy = 31'd1 << FRAC;
    int           mismatches = 0;
    int           corners_seen = 0;
    int           faces_sent = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    bit           no_idle = 0;
    bit           face_taken = 0;

    box_from_face_and_depth #(.FRAC_BITS(FRAC)) DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Divide by 2^sh, rounding half away from zero.
    function automatic longint round_shift(longint v, int sh);
        longint unsigned m;
        m = mag(v);
        m = (m + ((64'd1 << sh) >> 1)) >> sh;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic void predict_box(logic [383:0] face);
        longint p[3], a[3], b[3], c[3], n[3], v[3], h[3], q[3];
        longint unsigned m[3], big, sum, len, t;
        longint dep, w, d, s, half;
        bit flat;
        corner_word_t cw;
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(face[32*i +: 32]);
            a[i] = $signed(face[32*(3+i) +: 32]);
            b[i] = $signed(face[32*(6+i) +: 32]);
            n[i] = 0;
        end
        dep = $signed(face[32*9 +: 32]);
        if (mode_copy == MODE_REAL) w = $signed(face[32*10 +: 32]);
        else if (mode_copy == MODE_IMAG) w = $signed(face[32*11 +: 32]);
        else w = dep;
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        for (int i = 0; i < 3; i++) m[i] = mag(c[i]);
        big = m[0];
        if (m[1] > big) big = m[1];
        if (m[2] > big) big = m[2];
        flat = (big == 0);
        if (!flat) begin
            // Bring the largest magnitude into [2^30, 2^31) before the root.
            while (big >= (64'd1 << 31)) begin
                big >>= 1;
                for (int i = 0; i < 3; i++) m[i] >>= 1;
            end
            while (big < (64'd1 << 30)) begin
                big <<= 1;
                for (int i = 0; i < 3; i++) m[i] <<= 1;
            end
            sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                t = ((m[i] << FRAC) + (len >> 1)) / len;
                n[i] = c[i] < 0 ? -longint'(t) : longint'(t);
            end
        end
        for (int i = 0; i < 3; i++) begin
            d = round_shift(n[i] * dep, FRAC);
            v[i] = round_shift(n[i] * w, FRAC);
            h[i] = round_shift(d * longint'(ratio_copy), FRAC);
            half = (mag(h[i]) + 1) >>> 1;
            q[i] = p[i] + (h[i] < 0 ? half : -half);
        end
        for (int k = 0; k < CORNERS; k++) begin
            for (int i = 0; i < 3; i++) begin
                s = q[i];
                if (k[0]) s += a[i];
                if (k[1]) s += b[i];
                if (k[2]) s += h[i];
                cw.corner_data[32*i +: 32] = clamp32(s);
                cw.corner_data[32*(3+i) +: 32] = clamp32(v[i]);
            end
            cw.flags = {2'b00, flat, w == 0, dep == 0, k[2:0]};
            cw.last = (k == LAST_CORNER);
            expected_corners.push_back(cw);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Input side: a word leaves the bus only once it has been taken.
    always @(posedge aclk) begin
        face_taken = s_tvalid && s_tready;
        if (face_taken) begin
            predict_box(s_tdata);
            faces_sent++;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || face_taken)) begin
            if (send_gap > 0 || pending_faces.size() == 0) begin
                s_tvalid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end else begin
                s_tdata <= pending_faces.pop_front();
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end
        end
    end

    always @(negedge aclk) begin
        if (recv_gap > 0) begin
            m_tready <= 1'b0;
            recv_gap--;
        end else begin
            m_tready <= 1'b1;
            recv_gap = pick_gap();
        end
    end

    always @(posedge aclk) begin
        corner_word_t cw;
        bit bad;
        if (aresetn && m_tvalid && m_tready) begin
            corners_seen++;
            if (expected_corners.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected corner word %h", m_tdata);
            end else begin
                cw = expected_corners.pop_front();
                bad = (cw.flags != m_tuser) || (cw.last != m_tlast);
                for (int f = 0; f < 6; f++)
                    if (cw.corner_data[32*f +: 32] != m_tdata[32*f +: 32]) bad = 1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("corner mismatch: exp %h/%h/%b got %h/%h/%b",
                                 cw.corner_data, cw.flags, cw.last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [30:0] value);
        @(negedge aclk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == REG_MODE) mode_copy = value[1:0];
        else ratio_copy = value;
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_faces.size() != 0 || s_tvalid || expected_corners.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [383:0] make_face(logic [31:0] base, logic [31:0] ax,
            logic [31:0] ay, logic [31:0] bx, logic [31:0] by, logic [31:0] az,
            logic [31:0] bz, logic [31:0] dep, logic [31:0] jr, logic [31:0] ji);
        return {ji, jr, dep, bz, by, bx, az, ay, ax, base, base, base};
    endfunction

    // Random faces: mostly moderate values so the box is meaningful, some raw.
    function automatic logic [383:0] random_face();
        logic [383:0] f;
        int r;
        r = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++) begin
            if (r < 3) f[32*i +: 32] = $urandom;
            else f[32*i +: 32] = $signed($urandom_range(0, 2**22)) - 32'sd2097152;
        end
        if (r == 3) f[32*6 +: 96] = f[32*3 +: 96];
        if (r == 4) f[32*9 +: 32] = '0;
        if (r == 5) f[32*(9 + mode_copy % 3) +: 32] = '0;
        return f;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) pending_faces.push_back(random_face());
        wait_idle();
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed faces at reset settings.
        pending_faces.push_back(make_face('0, ONE, '0, '0, ONE, '0, '0, ONE, ONE, ONE));
        pending_faces.push_back(make_face(ONE, ONE, '0, ONE, '0, '0, '0, ONE, ONE, ONE));
        pending_faces.push_back(make_face('0, ONE, '0, '0, ONE, '0, '0, '0, '0, '0));
        pending_faces.push_back(make_face(MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MINV,
                                          MAXV, MAXV, MINV));
        pending_faces.push_back(make_face(MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV,
                                          MINV, MINV, MAXV));
        pending_faces.push_back(make_face(MAXV, MINV, MAXV, MAXV, MINV, MINV, MAXV,
                                          MINV, '0, '0));
        pending_faces.push_back('1);
        pending_faces.push_back('0);
        pending_faces.push_back(make_face(32'hfff0_0000, 32'd3, 32'd5, 32'hffff_fff9,
                                          32'd2, 32'd1, 32'd11, 32'hfffe_0000, ONE, ONE));
        wait_idle();
        run_random(30);

        write_reg(REG_MODE, 31'(MODE_REAL));
        write_reg(REG_HEIGHT, '0);
        pending_faces.push_back(make_face(ONE, ONE, '0, '0, ONE, '0, '0, ONE, '0, ONE));
        run_random(30);

        write_reg(REG_MODE, 31'(MODE_IMAG));
        write_reg(REG_HEIGHT, 31'h7fff_ffff);
        pending_faces.push_back(make_face(ONE, ONE, '0, '0, ONE, '0, '0, MAXV, ONE, '0));
        no_idle = 1;
        run_random(25);
        no_idle = 0;

        write_reg(REG_MODE, 31'd3);
        write_reg(REG_HEIGHT, 31'(32'h8000));
        run_random(30);

        write_reg(REG_MODE, 31'(MODE_DEPTH));
        write_reg(REG_HEIGHT, 31'($urandom & 32'h000f_ffff));
        run_random(30);

        $display("Sent %0d faces over five register settings and checked %0d corner words.",
                 faces_sent, corners_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d corner words were wrong.", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d corner words outstanding.", expected_corners.size());
        $display("end of test: mismatches");
        $finish;
    end
endmodule
